[hw/rtl/pol_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the positional ordered list.
// Used by pol_cell, pol_ctrl and positional_ordered_list; depends on nothing.
package pol_pkg;

  localparam int POL_CAPACITY = 64;
  localparam int CNT_W        = 7;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;

  // Operation codes carried in the input tuser field.
  localparam logic [KIND_W-1:0] KIND_APPEND   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REM_HEAD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_POS  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REM_POS  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST     = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Shift command broadcast to every cell.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_REM,
    OP_ROT
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [CNT_W-1:0]    idx;       // zero-based gap position for insert or remove
    logic [CNT_W-1:0]    last_idx;  // index of the tail entry, used while rotating
    logic [DATA_W-1:0]   value;     // value written at the gap on insert
  } cell_cmd_t;

endpackage

[hw/rtl/pol_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the ordered list: holds one entry and shifts with its neighbors.
// Depends on pol_pkg.
module pol_cell
  import pol_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  input  logic [DATA_W-1:0] head_i,
  output logic [DATA_W-1:0] data_o
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      OP_INS: begin
        if (IDX > cmd_i.idx) begin
          data_d = left_i;
        end else if (IDX == cmd_i.idx) begin
          data_d = cmd_i.value;
        end
      end
      OP_REM: begin
        if (IDX >= cmd_i.idx) begin
          data_d = right_i;
        end
      end
      OP_ROT: begin
        // The head wraps around to the tail so a full pass restores the order.
        if (IDX == cmd_i.last_idx) begin
          data_d = head_i;
        end else if (IDX < cmd_i.last_idx) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[hw/rtl/pol_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the ordered list: decodes operations, keeps the count, drives the
// cell command and the registered output stage. Depends on pol_pkg.
module pol_ctrl
  import pol_pkg::*;
#(
  parameter int CAPACITY = POL_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [DATA_W-1:0]   value_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [DATA_W-1:0]   head_i,
  output cell_cmd_t           cmd_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [DATA_W-1:0]   entry_value_o,
  output logic [CNT_W-1:0]    entry_count_o,
  output logic                last_o
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_LISTING
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    sent_q, sent_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DATA_W-1:0]   value_q, value_d;
  logic [CNT_W-1:0]    ocount_q, ocount_d;
  logic                last_q, last_d;

  logic             out_free;
  logic             accept;
  logic [POS_W-1:0] count_ext;
  logic [CNT_W-1:0] gap_idx;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign count_ext  = POS_W'(count_q);
  assign gap_idx    = CNT_W'(position_i - POS_W'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sent_d      = sent_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    value_d     = value_q;
    ocount_d    = ocount_q;
    last_d      = last_q;

    cmd_o          = '0;
    cmd_o.op       = OP_HOLD;
    cmd_o.value    = value_i;
    cmd_o.last_idx = count_q - CNT_W'(1);

    if (accept) begin
      status_d = ST_OK;
      value_d  = '0;
      last_d   = 1'b1;
      unique case (kind_i)
        KIND_APPEND: begin
          out_valid_d = 1'b1;
          if (count_q >= CAP) begin
            status_d = ST_FULL;
          end else begin
            cmd_o.op  = OP_INS;
            cmd_o.idx = count_q;
            count_d   = count_q + CNT_W'(1);
          end
        end
        KIND_REM_HEAD: begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            cmd_o.op  = OP_REM;
            cmd_o.idx = '0;
            count_d   = count_q - CNT_W'(1);
          end
        end
        KIND_INS_POS: begin
          out_valid_d = 1'b1;
          if (position_i == '0 || position_i > count_ext + POS_W'(1)) begin
            status_d = ST_INVALID;
          end else if (count_q >= CAP) begin
            status_d = ST_FULL;
          end else begin
            cmd_o.op  = OP_INS;
            cmd_o.idx = gap_idx;
            count_d   = count_q + CNT_W'(1);
          end
        end
        KIND_REM_POS: begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else if (position_i == '0 || position_i > count_ext) begin
            status_d = ST_INVALID;
          end else begin
            cmd_o.op  = OP_REM;
            cmd_o.idx = gap_idx;
            count_d   = count_q - CNT_W'(1);
          end
        end
        KIND_LIST: begin
          if (count_q == '0) begin
            out_valid_d = 1'b1;
            status_d    = ST_EMPTY;
          end else begin
            state_d = ST_LISTING;
            sent_d  = '0;
          end
        end
        default: begin
          out_valid_d = out_valid_q && !out_ready_i;
        end
      endcase
      ocount_d = count_d;
    end else if (state_q == ST_LISTING && out_free) begin
      // Emit the head and rotate the chain by one place.
      cmd_o.op    = OP_ROT;
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      value_d     = head_i;
      ocount_d    = count_q;
      sent_d      = sent_q + CNT_W'(1);
      last_d      = (sent_q + CNT_W'(1) == count_q);
      if (sent_q + CNT_W'(1) == count_q) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    value_q  <= value_d;
    ocount_q <= ocount_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_value_o = value_q;
  assign entry_count_o = ocount_q;
  assign last_o        = last_q;

endmodule

[hw/rtl/positional_ordered_list.sv]
`timescale 1ns / 1ps
// Positional ordered list: a bounded list of signed 32-bit values held in a row of
// shifting cells. Channels: a slave stream carries one operation per transfer
// (tuser = kind; tdata = value, then position) and a master stream returns results
// (tuser = status; tdata = entry value, then entry count; tlast marks the final
// result of an operation).
// Append, remove head, insert at position and remove at position each give one
// status result from the registered output stage; the cells shift at the end of the
// cycle the transfer is taken, so a new operation can be taken every cycle while results are drained.
// A list operation on a non-empty list first enters a listing state, then streams one
// entry per cycle while the receiver takes them, by rotating the cell chain through
// the head. The next operation can be taken in the cycle the last entry is
// transferred out. An empty list gives one empty status.
// Reset clears the count and the output valid flag; cell contents are not reset and are
// never read before being written. When the receiver stalls, the output register
// holds its result and the input stream is held off until that result is taken.
// Depends on pol_pkg, pol_cell and pol_ctrl.
module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int CAPACITY = POL_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] value, [39:32] position
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] entry_value, [38:32] entry_count, [39] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);

  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] entry_value;
  logic [CNT_W-1:0]  entry_count;

  pol_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .kind_i        (s_axis_tuser),
    .value_i       (s_axis_tdata[31:0]),
    .position_i    (s_axis_tdata[39:32]),
    .head_i        (cell_data[0]),
    .cmd_o         (cmd),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .status_o      (m_axis_tuser),
    .entry_value_o (entry_value),
    .entry_count_o (entry_count),
    .last_o        (m_axis_tlast)
  );

  // Each cell sees its two neighbors; the ends see themselves, so taking that input
  // leaves them unchanged.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_mid_left
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_right
      assign right_d = cell_data[i+1];
    end

    pol_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_d),
      .right_i (right_d),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  assign m_axis_tdata = {1'b0, entry_count, entry_value};

endmodule
